// ===== hw/rtl/zpw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zpw_pkg: shared types and constants
// Command codes, register map, datapath op codes and the control/status
// bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package zpw_pkg;

	localparam int ZW        = 16;  // zoom width, unsigned
	localparam int PAN_W     = 16;  // pan width, signed Q2.14
	localparam int LOG_FRAC  = 12;  // fraction bits of the log result
	localparam int LIM_SHIFT = 14;  // limit is (e-b)*2^14/e
	localparam int MUL_W     = 32;  // shared multiplier operand width
	localparam int DIV_QW    = 32;  // divider numerator/quotient width
	localparam int DIV_CW    = 6;   // divider step counter
	localparam int LOG_MW    = 31;  // log mantissa, 1.30
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [1:0] CMD_RESET = 2'd0;
	localparam logic [1:0] CMD_ZOOM  = 2'd1;
	localparam logic [1:0] CMD_PAN   = 2'd2;

	localparam logic [2:0] REG_ZOOM_FLOOR     = 3'd0;
	localparam logic [2:0] REG_ZOOM_CEILING   = 3'd1;
	localparam logic [2:0] REG_VIDEO_WIDTH    = 3'd2;
	localparam logic [2:0] REG_VIDEO_HEIGHT   = 3'd3;
	localparam logic [2:0] REG_DISPLAY_WIDTH  = 3'd4;
	localparam logic [2:0] REG_DISPLAY_HEIGHT = 3'd5;
	localparam logic [2:0] REG_DIMS_KNOWN     = 3'd6;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_RESET_VIEW,
		OP_ZOOM_STEP,
		OP_DIVX_START,
		OP_PANX,
		OP_DIVY_START,
		OP_PANY,
		OP_ZERO_PANS,
		OP_UNIT_PREP,
		OP_LIMU_ZERO,
		OP_DIV_LIM_START,
		OP_LIMU_TAKE,
		OP_MUL_VA,
		OP_MUL_DA,
		OP_SAVE_DA,
		OP_MUL_E,
		OP_MUL_B,
		OP_SAVE_B,
		OP_LIMO_ZERO,
		OP_LIMO_TAKE,
		OP_CLAMP,
		OP_LOG_INIT,
		OP_LOG_SQ,
		OP_LOG_ADJ,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       at_floor;
		logic       dims_known;
		logic       e_le_b;
		logic       div_done;
		logic       log_last;
		logic       out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/zpw_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zpw_in_if: command channel
// Valid/ready channel carrying one zoom/pan command.
// ----------------------------------------------------------------------------
interface zpw_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [15:0] zoom_step;
	logic signed [15:0] pan_step_x;
	logic signed [15:0] pan_step_y;

	modport source (output valid, cmd, zoom_step, pan_step_x, pan_step_y, input ready);
	modport sink   (input valid, cmd, zoom_step, pan_step_x, pan_step_y, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/zpw_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zpw_out_if: result channel
// Valid/ready channel carrying zoom, its log2 and both pans.
// ----------------------------------------------------------------------------
interface zpw_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        zoom_now;
	logic signed [15:0] zoom_log2;
	logic signed [15:0] pan_x_now;
	logic signed [15:0] pan_y_now;

	modport source (output valid, zoom_now, zoom_log2, pan_x_now, pan_y_now, input ready);
	modport sink   (input valid, zoom_now, zoom_log2, pan_x_now, pan_y_now, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/zoom_pan_window_limiter_core.sv =====
// A command runs from its transfer to result valid, held by output stalls: a
// reset or zoom at or below the floor zeroes the pans and goes to the log2,
// else it runs the limit divisions, the aspect products (dims known) and 12
// log2 rounds; a pan step first adds two divisions. One command in flight; the
// next is taken once the result is registered, or once an ignored one is dropped.
// Reset (arst_n low) clears zoom to 1.0, pans to 0 and registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zoom_pan_window_limiter_core: zoom/pan window limiter
// Config registers on APB, command in, zoom/log2/pan result out.
// ----------------------------------------------------------------------------
module zoom_pan_window_limiter_core import zpw_pkg::*; #(
	parameter int ZOOM_FRAC_BITS = 12,
	parameter int DIM_BITS       = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	zpw_in_if.sink            in_ch,
	zpw_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);
	logic [ZW-1:0]       zoom_floor_q, zoom_ceiling_q;
	logic [DIM_BITS-1:0] video_width_q, video_height_q;
	logic [DIM_BITS-1:0] display_width_q, display_height_q;
	logic                dims_known_q;
	logic [2:0]          reg_idx;
	logic                wr_en;
	dp_cmd_t             dp_cmd;
	dp_stat_t            dp_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_floor_q     <= 16'd4096;
			zoom_ceiling_q   <= 16'd16384;
			video_width_q    <= DIM_BITS'(1920);
			video_height_q   <= DIM_BITS'(1080);
			display_width_q  <= DIM_BITS'(1920);
			display_height_q <= DIM_BITS'(1080);
			dims_known_q     <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ZOOM_FLOOR:     zoom_floor_q     <= pwdata[ZW-1:0];
				REG_ZOOM_CEILING:   zoom_ceiling_q   <= pwdata[ZW-1:0];
				REG_VIDEO_WIDTH:    video_width_q    <= pwdata[DIM_BITS-1:0];
				REG_VIDEO_HEIGHT:   video_height_q   <= pwdata[DIM_BITS-1:0];
				REG_DISPLAY_WIDTH:  display_width_q  <= pwdata[DIM_BITS-1:0];
				REG_DISPLAY_HEIGHT: display_height_q <= pwdata[DIM_BITS-1:0];
				REG_DIMS_KNOWN:     dims_known_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ZOOM_FLOOR:     prdata = DATA_W'(zoom_floor_q);
			REG_ZOOM_CEILING:   prdata = DATA_W'(zoom_ceiling_q);
			REG_VIDEO_WIDTH:    prdata = DATA_W'(video_width_q);
			REG_VIDEO_HEIGHT:   prdata = DATA_W'(video_height_q);
			REG_DISPLAY_WIDTH:  prdata = DATA_W'(display_width_q);
			REG_DISPLAY_HEIGHT: prdata = DATA_W'(display_height_q);
			REG_DIMS_KNOWN:     prdata = DATA_W'(dims_known_q);
			default:            prdata = '0;
		endcase
	end

	zpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	zpw_datapath #(
		.ZOOM_FRAC_BITS (ZOOM_FRAC_BITS),
		.DIM_BITS       (DIM_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.stat           (dp_stat),
		.in_cmd         (in_ch.cmd),
		.in_zoom_step   (in_ch.zoom_step),
		.in_pan_step_x  (in_ch.pan_step_x),
		.in_pan_step_y  (in_ch.pan_step_y),
		.zoom_floor     (zoom_floor_q),
		.zoom_ceiling   (zoom_ceiling_q),
		.video_width    (video_width_q),
		.video_height   (video_height_q),
		.display_width  (display_width_q),
		.display_height (display_height_q),
		.dims_known     (dims_known_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_zoom_now   (out_ch.zoom_now),
		.out_zoom_log2  (out_ch.zoom_log2),
		.out_pan_x_now  (out_ch.pan_x_now),
		.out_pan_y_now  (out_ch.pan_y_now)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/zpw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zpw_div: bit-serial restoring divider
// One quotient bit per cycle; remainder preload lets it extend a fraction.
// ----------------------------------------------------------------------------
module zpw_div import zpw_pkg::*; #(
	parameter int DW = 44
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     rem_init,
	input  logic [DIV_QW-1:0] num_init,
	input  logic [DW-1:0]     divisor,
	input  logic [DIV_CW-1:0] steps,
	output logic [DIV_QW-1:0] quo,
	output logic              done
);
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     div_q;
	logic [DIV_QW-1:0] num_q;
	logic [DIV_QW-1:0] quo_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DW:0]       trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_QW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			div_q <= divisor;
			num_q <= num_init;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : DW'(trial);
			num_q <= {num_q[DIV_QW-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QW-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== hw/rtl/zpw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zpw_ctrl: command sequencer
// Walks one command through update, limit, log and output steps.
// ----------------------------------------------------------------------------
module zpw_ctrl import zpw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [20:0] {
		ST_IDLE   = 21'd1 << 0,
		ST_DECODE = 21'd1 << 1,
		ST_DIVX   = 21'd1 << 2,
		ST_DIVY0  = 21'd1 << 3,
		ST_DIVY   = 21'd1 << 4,
		ST_LIM    = 21'd1 << 5,
		ST_UDIV   = 21'd1 << 6,
		ST_UWAIT  = 21'd1 << 7,
		ST_AXIS   = 21'd1 << 8,
		ST_MULDA  = 21'd1 << 9,
		ST_SAVEDA = 21'd1 << 10,
		ST_MULE   = 21'd1 << 11,
		ST_MULB   = 21'd1 << 12,
		ST_SAVEB  = 21'd1 << 13,
		ST_ODIV   = 21'd1 << 14,
		ST_OWAIT  = 21'd1 << 15,
		ST_CLAMP  = 21'd1 << 16,
		ST_LOGN   = 21'd1 << 17,
		ST_LOGSQ  = 21'd1 << 18,
		ST_LOGADJ = 21'd1 << 19,
		ST_OUT    = 21'd1 << 20
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.cmd)
					CMD_RESET: begin
						cmd.op  = OP_RESET_VIEW;
						state_d = ST_LIM;
					end
					CMD_ZOOM: begin
						cmd.op  = OP_ZOOM_STEP;
						state_d = ST_LIM;
					end
					CMD_PAN: begin
						if (stat.at_floor) begin
							state_d = ST_IDLE;
						end else begin
							cmd.op  = OP_DIVX_START;
							state_d = ST_DIVX;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIVX: begin
				if (stat.div_done) begin
					cmd.op  = OP_PANX;
					state_d = ST_DIVY0;
				end
			end
			ST_DIVY0: begin
				cmd.op  = OP_DIVY_START;
				state_d = ST_DIVY;
			end
			ST_DIVY: begin
				if (stat.div_done) begin
					cmd.op  = OP_PANY;
					state_d = ST_LIM;
				end
			end
			ST_LIM: begin
				if (stat.at_floor) begin
					cmd.op  = OP_ZERO_PANS;
					state_d = ST_LOGN;
				end else begin
					cmd.op  = OP_UNIT_PREP;
					state_d = ST_UDIV;
				end
			end
			ST_UDIV: begin
				if (stat.e_le_b) begin
					cmd.op  = OP_LIMU_ZERO;
					state_d = ST_AXIS;
				end else begin
					cmd.op  = OP_DIV_LIM_START;
					state_d = ST_UWAIT;
				end
			end
			ST_UWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_LIMU_TAKE;
					state_d = ST_AXIS;
				end
			end
			ST_AXIS: begin
				if (stat.dims_known) begin
					cmd.op  = OP_MUL_VA;
					state_d = ST_MULDA;
				end else begin
					state_d = ST_CLAMP;
				end
			end
			ST_MULDA: begin
				cmd.op  = OP_MUL_DA;
				state_d = ST_SAVEDA;
			end
			ST_SAVEDA: begin
				cmd.op  = OP_SAVE_DA;
				state_d = ST_MULE;
			end
			ST_MULE: begin
				cmd.op  = OP_MUL_E;
				state_d = ST_MULB;
			end
			ST_MULB: begin
				cmd.op  = OP_MUL_B;
				state_d = ST_SAVEB;
			end
			ST_SAVEB: begin
				cmd.op  = OP_SAVE_B;
				state_d = ST_ODIV;
			end
			ST_ODIV: begin
				if (stat.e_le_b) begin
					cmd.op  = OP_LIMO_ZERO;
					state_d = ST_CLAMP;
				end else begin
					cmd.op  = OP_DIV_LIM_START;
					state_d = ST_OWAIT;
				end
			end
			ST_OWAIT: begin
				if (stat.div_done) begin
					cmd.op  = OP_LIMO_TAKE;
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				cmd.op  = OP_CLAMP;
				state_d = ST_LOGN;
			end
			ST_LOGN: begin
				cmd.op  = OP_LOG_INIT;
				state_d = ST_LOGSQ;
			end
			ST_LOGSQ: begin
				cmd.op  = OP_LOG_SQ;
				state_d = ST_LOGADJ;
			end
			ST_LOGADJ: begin
				cmd.op  = OP_LOG_ADJ;
				state_d = stat.log_last ? ST_OUT : ST_LOGSQ;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/zpw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zpw_datapath: zoom/pan state and arithmetic
// Shared 32x32 multiplier, serial divider, log2 by repeated squaring,
// and the output register.
// ----------------------------------------------------------------------------
module zpw_datapath import zpw_pkg::*; #(
	parameter int ZOOM_FRAC_BITS = 12,
	parameter int DIM_BITS       = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [1:0]          in_cmd,
	input  logic signed [15:0]  in_zoom_step,
	input  logic signed [15:0]  in_pan_step_x,
	input  logic signed [15:0]  in_pan_step_y,
	input  logic [ZW-1:0]       zoom_floor,
	input  logic [ZW-1:0]       zoom_ceiling,
	input  logic [DIM_BITS-1:0] video_width,
	input  logic [DIM_BITS-1:0] video_height,
	input  logic [DIM_BITS-1:0] display_width,
	input  logic [DIM_BITS-1:0] display_height,
	input  logic                dims_known,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ZW-1:0]       out_zoom_now,
	output logic signed [15:0]  out_zoom_log2,
	output logic signed [15:0]  out_pan_x_now,
	output logic signed [15:0]  out_pan_y_now
);
	localparam int PW = 2 * DIM_BITS;
	localparam int EW = ZW + PW;
	localparam logic [ZW-1:0] UNIT =
		((1 << ZOOM_FRAC_BITS) > 65535) ? 16'hFFFF : ZW'(1 << ZOOM_FRAC_BITS);

	// captured command
	logic [1:0]         cmd_q;
	logic signed [15:0] zstep_q, psx_q, psy_q;

	// view state
	logic [ZW-1:0]          zoom_q;
	logic signed [PAN_W-1:0] pan_x_q, pan_y_q;

	// limit path
	logic [PW-1:0]        va_q, da_q;
	logic [EW-1:0]        e_q, b_q;
	logic [LIM_SHIFT-1:0] lim_u_q, lim_o_q;
	logic [2*MUL_W-1:0]   prod_q;
	logic [MUL_W-1:0]     mul_a, mul_b;
	logic                 x_fill;

	// log path
	logic [LOG_MW-1:0]   m_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [3:0]          lexp_q, lcnt_q, ltop;
	logic                zzero_q;
	logic [MUL_W-1:0]    sq_t;

	// divider hookup
	logic              div_start, div_done;
	logic [EW-1:0]     div_rem, div_dvs;
	logic [DIV_QW-1:0] div_num, div_quo;
	logic [DIV_CW-1:0] div_steps;
	logic [15:0]       mag_x, mag_y;

	// zoom step
	logic signed [17:0] zsum, zlo, zclamp;

	// output register
	logic                out_valid_q;
	logic [ZW-1:0]       out_zoom_q;
	logic signed [15:0]  out_log_q, out_px_q, out_py_q;
	logic signed [6:0]   lexp_s;
	logic signed [18:0]  lval;
	logic signed [15:0]  log_res;
	logic [LIM_SHIFT-1:0] mx_lim, my_lim;

	function automatic logic signed [15:0] pan_add(logic signed [15:0] pan, logic neg,
			logic [DIV_QW-1:0] q);
		logic signed [33:0] d;
		logic signed [33:0] s;
		d = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
		s = 34'(pan) + d;
		if (s > 34'sd32767) begin
			return 16'sh7FFF;
		end else if (s < -34'sd32768) begin
			return 16'sh8000;
		end
		return 16'(s);
	endfunction

	function automatic logic signed [15:0] clamp_sym(logic signed [15:0] p,
			logic [LIM_SHIFT-1:0] lim);
		logic signed [15:0] m;
		m = $signed({2'b00, lim});
		if (p > m) begin
			return m;
		end else if (p < -m) begin
			return -m;
		end
		return p;
	endfunction

	assign x_fill = va_q >= da_q;
	assign mag_x  = psx_q[15] ? 16'(-$signed({psx_q[15], psx_q})) : 16'(psx_q);
	assign mag_y  = psy_q[15] ? 16'(-$signed({psy_q[15], psy_q})) : 16'(psy_q);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_VA: begin
				mul_a = MUL_W'(video_width);
				mul_b = MUL_W'(display_height);
			end
			OP_MUL_DA: begin
				mul_a = MUL_W'(display_width);
				mul_b = MUL_W'(video_height);
			end
			OP_MUL_E: begin
				mul_a = MUL_W'(zoom_q);
				mul_b = x_fill ? MUL_W'(da_q) : MUL_W'(va_q);
			end
			OP_MUL_B: begin
				mul_a = MUL_W'(UNIT);
				mul_b = x_fill ? MUL_W'(va_q) : MUL_W'(da_q);
			end
			OP_LOG_SQ: begin
				mul_a = MUL_W'(m_q);
				mul_b = MUL_W'(m_q);
			end
			default: ;
		endcase
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_rem   = '0;
		div_num   = '0;
		div_dvs   = EW'(zoom_q);
		div_steps = DIV_CW'(DIV_QW);
		case (cmd.op)
			OP_DIVX_START: begin
				div_start = 1'b1;
				div_num   = DIV_QW'(mag_x) << ZOOM_FRAC_BITS;
			end
			OP_DIVY_START: begin
				div_start = 1'b1;
				div_num   = DIV_QW'(mag_y) << ZOOM_FRAC_BITS;
			end
			OP_DIV_LIM_START: begin
				div_start = 1'b1;
				div_rem   = e_q - b_q;
				div_dvs   = e_q;
				div_steps = DIV_CW'(LIM_SHIFT);
			end
			default: ;
		endcase
	end

	zpw_div #(.DW(EW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.num_init (div_num),
		.divisor  (div_dvs),
		.steps    (div_steps),
		.quo      (div_quo),
		.done     (div_done)
	);

	// zoom step: floor first, then ceiling
	always_comb begin
		zsum   = $signed({2'b00, zoom_q}) + 18'(zstep_q);
		zlo    = (zsum < $signed({2'b00, zoom_floor})) ? $signed({2'b00, zoom_floor}) : zsum;
		zclamp = (zlo > $signed({2'b00, zoom_ceiling})) ? $signed({2'b00, zoom_ceiling}) : zlo;
	end

	always_comb begin
		ltop = '0;
		for (int i = 0; i < ZW; i++) begin
			if (zoom_q[i]) begin
				ltop = 4'(i);
			end
		end
	end

	assign sq_t = prod_q[2*LOG_MW-1:LOG_MW-1];

	always_comb begin
		if (!dims_known || x_fill) begin
			mx_lim = lim_u_q;
		end else begin
			mx_lim = lim_o_q;
		end
		if (dims_known && x_fill) begin
			my_lim = lim_o_q;
		end else begin
			my_lim = lim_u_q;
		end
	end

	// log2 = (e - frac bits) * 4096 + fraction, saturated
	always_comb begin
		lexp_s = $signed({3'b000, lexp_q}) - 7'(ZOOM_FRAC_BITS);
		lval   = $signed({lexp_s, 12'b0}) + $signed({7'b0, frac_q});
		if (zzero_q || lval < -19'sd32768) begin
			log_res = 16'sh8000;
		end else if (lval > 19'sd32767) begin
			log_res = 16'sh7FFF;
		end else begin
			log_res = 16'(lval);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q      <= UNIT;
			pan_x_q     <= '0;
			pan_y_q     <= '0;
			lcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_RESET_VIEW: begin
					zoom_q  <= UNIT;
					pan_x_q <= '0;
					pan_y_q <= '0;
				end
				OP_ZOOM_STEP: zoom_q <= ZW'(zclamp);
				OP_PANX: pan_x_q <= pan_add(pan_x_q, psx_q[15], div_quo);
				OP_PANY: pan_y_q <= pan_add(pan_y_q, psy_q[15], div_quo);
				OP_ZERO_PANS: begin
					pan_x_q <= '0;
					pan_y_q <= '0;
				end
				OP_CLAMP: begin
					pan_x_q <= clamp_sym(pan_x_q, mx_lim);
					pan_y_q <= clamp_sym(pan_y_q, my_lim);
				end
				OP_LOG_INIT: lcnt_q <= '0;
				OP_LOG_ADJ: lcnt_q <= lcnt_q + 1'b1;
				OP_EMIT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				cmd_q   <= in_cmd;
				zstep_q <= in_zoom_step;
				psx_q   <= in_pan_step_x;
				psy_q   <= in_pan_step_y;
			end
			OP_UNIT_PREP: begin
				e_q <= EW'(zoom_q);
				b_q <= EW'(UNIT);
			end
			OP_LIMU_ZERO: lim_u_q <= '0;
			OP_LIMU_TAKE: lim_u_q <= div_quo[LIM_SHIFT-1:0];
			OP_LIMO_ZERO: lim_o_q <= '0;
			OP_LIMO_TAKE: lim_o_q <= div_quo[LIM_SHIFT-1:0];
			OP_MUL_VA: prod_q <= mul_a * mul_b;
			OP_MUL_DA: begin
				va_q   <= prod_q[PW-1:0];
				prod_q <= mul_a * mul_b;
			end
			OP_SAVE_DA: da_q <= prod_q[PW-1:0];
			OP_MUL_E: prod_q <= mul_a * mul_b;
			OP_MUL_B: begin
				e_q    <= prod_q[EW-1:0];
				prod_q <= mul_a * mul_b;
			end
			OP_SAVE_B: b_q <= prod_q[EW-1:0];
			OP_LOG_INIT: begin
				zzero_q <= zoom_q == '0;
				lexp_q  <= ltop;
				m_q     <= LOG_MW'(zoom_q) << (5'd30 - 5'(ltop));
				frac_q  <= '0;
			end
			OP_LOG_SQ: prod_q <= mul_a * mul_b;
			OP_LOG_ADJ: begin
				frac_q <= {frac_q[LOG_FRAC-2:0], sq_t[MUL_W-1]};
				m_q    <= sq_t[MUL_W-1] ? sq_t[MUL_W-1:1] : sq_t[LOG_MW-1:0];
			end
			OP_EMIT: begin
				out_zoom_q <= zoom_q;
				out_log_q  <= log_res;
				out_px_q   <= pan_x_q;
				out_py_q   <= pan_y_q;
			end
			default: ;
		endcase
	end

	assign stat.cmd        = cmd_q;
	assign stat.at_floor   = zoom_q <= zoom_floor;
	assign stat.dims_known = dims_known;
	assign stat.e_le_b     = e_q <= b_q;
	assign stat.div_done   = div_done;
	assign stat.log_last   = lcnt_q == 4'(LOG_FRAC - 1);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_zoom_now  = out_zoom_q;
	assign out_zoom_log2 = out_log_q;
	assign out_pan_x_now = out_px_q;
	assign out_pan_y_now = out_py_q;
endmodule
`default_nettype wire

// ===== hw/rtl/zpw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zpw_checker: port-level checks
// Result handshake, one command at a time, and pan range.
// ----------------------------------------------------------------------------
module zpw_checker import zpw_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [15:0]        zoom_now,
	input wire logic signed [15:0] pan_x_now,
	input wire logic signed [15:0] pan_y_now
);
	localparam logic signed [15:0] PAN_MAX = 16'((1 << LIM_SHIFT) - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(zoom_now) && $stable(pan_x_now)
			&& $stable(pan_y_now))
		else $error("result changed while stalled");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while one is in work");

	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pan_x_now <= PAN_MAX && pan_x_now >= -PAN_MAX
			&& pan_y_now <= PAN_MAX && pan_y_now >= -PAN_MAX)
		else $error("pan outside half-window limit");
endmodule

bind zoom_pan_window_limiter_core zpw_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.zoom_now  (out_ch.zoom_now),
	.pan_x_now (out_ch.pan_x_now),
	.pan_y_now (out_ch.pan_y_now)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: zoom/pan window limiter core
// Writes the register file over APB, sends directed and random zoom/pan
// commands with bursty traffic and output stalls, and checks every result
// against a cycle-free predictor of the zoom, log2 and clamped pans.
// ----------------------------------------------------------------------------
module testbench;
	import zpw_pkg::*;

	localparam logic [1:0] CMD_UNDEF = 2'd3;
	localparam int         DRAIN_CYCLES = 250;
	localparam int         CYCLE_LIMIT  = 1_000_000;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [15:0] zoom_step;
		logic signed [15:0] pan_step_x;
		logic signed [15:0] pan_step_y;
	} view_cmd_t;

	typedef struct {
		logic [15:0]        zoom_now;
		logic signed [15:0] zoom_log2;
		logic signed [15:0] pan_x_now;
		logic signed [15:0] pan_y_now;
	} view_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	zpw_in_if  in_ch ();
	zpw_out_if out_ch ();

	zoom_pan_window_limiter_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state and register shadow
	longint unsigned floor_q, ceil_q, vid_w, vid_h, disp_w, disp_h;
	bit              dims_ok;
	longint unsigned zoom_q;
	int              pan_x, pan_y;

	view_cmd_t cmd_backlog[$];
	view_t     views_due[$];
	int        fails;
	int        cycles;
	bit        took;
	int        burst_left, gap_left, gap_max;
	int        stall_mode;

	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	function automatic int sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	function automatic int axis_limit(longint unsigned z, longint unsigned n,
			longint unsigned d);
		longint unsigned e;
		longint unsigned b;
		e = z * n;
		b = 64'd4096 * d;
		if (e <= b) return 0;
		return int'(((e - b) << LIM_SHIFT) / e);
	endfunction

	function automatic int clamp_sym(int p, int m);
		if (p > m) return m;
		if (p < -m) return -m;
		return p;
	endfunction

	function automatic int zoom_log2_of(longint unsigned z);
		int              e;
		int              frac;
		longint unsigned m;
		if (z == 0) return -32768;
		e = 15;
		while (z[e] == 1'b0) e--;
		m = z << (30 - e);
		frac = 0;
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return sat16(longint'(e - 12) * 4096 + frac);
	endfunction

	function automatic int pan_delta(int step);
		longint mag;
		longint q;
		mag = (step < 0) ? -longint'(step) : longint'(step);
		q = (mag << 12) / longint'(zoom_q);
		return int'((step < 0) ? -q : q);
	endfunction

	// returns 1 when the command yields a result
	function automatic bit advance_view(view_cmd_t c, output view_t v);
		longint          z;
		longint unsigned va, da;
		int              mx, my;
		v = '{default: '0};
		case (c.cmd)
			CMD_RESET: begin
				zoom_q = 4096;
				pan_x = 0;
				pan_y = 0;
			end
			CMD_ZOOM: begin
				z = longint'(zoom_q) + longint'(c.zoom_step);
				if (z < longint'(floor_q)) z = longint'(floor_q);
				if (z > longint'(ceil_q)) z = longint'(ceil_q);
				zoom_q = longint'(z);
			end
			CMD_PAN: begin
				if (zoom_q <= floor_q) return 0;
				pan_x = sat16(longint'(pan_x) + pan_delta(int'(c.pan_step_x)));
				pan_y = sat16(longint'(pan_y) + pan_delta(int'(c.pan_step_y)));
			end
			default: return 0;
		endcase
		if (zoom_q <= floor_q) begin
			pan_x = 0;
			pan_y = 0;
		end else begin
			if (dims_ok) begin
				va = vid_w * disp_h;
				da = disp_w * vid_h;
				if (va >= da) begin
					mx = axis_limit(zoom_q, 1, 1);
					my = axis_limit(zoom_q, da, va);
				end else begin
					my = axis_limit(zoom_q, 1, 1);
					mx = axis_limit(zoom_q, va, da);
				end
			end else begin
				mx = axis_limit(zoom_q, 1, 1);
				my = mx;
			end
			pan_x = clamp_sym(pan_x, mx);
			pan_y = clamp_sym(pan_y, my);
		end
		v.zoom_now  = zoom_q[15:0];
		v.zoom_log2 = 16'(zoom_log2_of(zoom_q));
		v.pan_x_now = 16'(pan_x);
		v.pan_y_now = 16'(pan_y);
		return 1;
	endfunction

	task automatic apb_write(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_W'({idx, 2'b00});
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (idx)
			REG_ZOOM_FLOOR:     floor_q = value[15:0];
			REG_ZOOM_CEILING:   ceil_q  = value[15:0];
			REG_VIDEO_WIDTH:    vid_w   = value[13:0];
			REG_VIDEO_HEIGHT:   vid_h   = value[13:0];
			REG_DISPLAY_WIDTH:  disp_w  = value[13:0];
			REG_DISPLAY_HEIGHT: disp_h  = value[13:0];
			REG_DIMS_KNOWN:     dims_ok = value[0];
			default: ;
		endcase
	endtask

	task automatic set_view_regs(int fl, int ce, int vw, int vh, int dw, int dh, bit dk);
		apb_write(REG_ZOOM_FLOOR, fl);
		apb_write(REG_ZOOM_CEILING, ce);
		apb_write(REG_VIDEO_WIDTH, vw);
		apb_write(REG_VIDEO_HEIGHT, vh);
		apb_write(REG_DISPLAY_WIDTH, dw);
		apb_write(REG_DISPLAY_HEIGHT, dh);
		apb_write(REG_DIMS_KNOWN, dk);
	endtask

	task automatic queue_cmd(logic [1:0] c, int zs, int px, int py);
		view_cmd_t item;
		item.cmd        = c;
		item.zoom_step  = 16'(zs);
		item.pan_step_x = 16'(px);
		item.pan_step_y = 16'(py);
		cmd_backlog.push_back(item);
	endtask

	// wait for the block to go idle; ignored commands give no result, so linger
	task automatic drain_phase();
		do @(posedge clk);
		while (cmd_backlog.size() != 0 || in_ch.valid || views_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		int r;
		int zs, px, py;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			zs = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
			                              : int'($urandom_range(4096)) - 2048;
			if ($urandom_range(3) == 0) begin
				px = int'($urandom_range(65535)) - 32768;
				py = int'($urandom_range(65535)) - 32768;
			end else begin
				px = int'($urandom_range(8192)) - 4096;
				py = int'($urandom_range(8192)) - 4096;
			end
			if (r < 3)       queue_cmd(CMD_RESET, zs, px, py);
			else if (r < 40) queue_cmd(CMD_ZOOM, zs, px, py);
			else if (r < 97) queue_cmd(CMD_PAN, zs, px, py);
			else             queue_cmd(CMD_UNDEF, zs, px, py);
		end
	endtask

	// stimulus
	initial begin
		fails = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.cmd = CMD_RESET;
		in_ch.zoom_step = '0; in_ch.pan_step_x = '0; in_ch.pan_step_y = '0;
		out_ch.ready = 1'b0;
		floor_q = 4096; ceil_q = 16384; vid_w = 1920; vid_h = 1080;
		disp_w = 1920; disp_h = 1080; dims_ok = 1'b0;
		zoom_q = 4096; pan_x = 0; pan_y = 0;
		gap_max = 8; stall_mode = 1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values
		queue_cmd(CMD_PAN, 0, 32767, -32768);      // pan at floor: no result
		queue_cmd(CMD_UNDEF, 100, 5, 5);           // undefined code: ignored
		queue_cmd(CMD_ZOOM, 32767, 0, 0);          // hits ceiling
		queue_cmd(CMD_PAN, 0, 32767, 32767);
		queue_cmd(CMD_PAN, 0, -32768, -32768);
		queue_cmd(CMD_PAN, 0, -1, 1);
		queue_cmd(CMD_ZOOM, -8192, 0, 0);
		queue_cmd(CMD_PAN, 0, 32767, -32768);
		queue_cmd(CMD_ZOOM, -32768, 0, 0);         // back to floor, pans zeroed
		queue_cmd(CMD_ZOOM, 1, 0, 0);
		queue_cmd(CMD_PAN, 0, 1, -1);
		queue_cmd(CMD_RESET, -1, -1, -1);
		drain_phase();

		// floor 0: zoom below one but above floor, and zero zoom for log2
		set_view_regs(0, 65535, 16383, 1, 1, 16383, 1'b1);
		queue_cmd(CMD_ZOOM, -4095, 0, 0);
		queue_cmd(CMD_PAN, 0, 32767, 32767);
		queue_cmd(CMD_ZOOM, -32768, 0, 0);
		queue_cmd(CMD_ZOOM, 32767, 0, 0);
		queue_cmd(CMD_ZOOM, 32767, 0, 0);
		queue_cmd(CMD_PAN, 0, -32768, 32767);
		queue_cmd(CMD_PAN, 0, 32767, -32768);
		drain_phase();
		// floor above ceiling: ceiling wins; zero ceiling gives zero zoom
		set_view_regs(20000, 0, 1, 16383, 16383, 1, 1'b1);
		queue_cmd(CMD_ZOOM, 5, 0, 0);
		queue_cmd(CMD_PAN, 0, 100, 100);
		drain_phase();

		gap_max = 0; stall_mode = 0;
		set_view_regs(4096, 16384, 1920, 1080, 1920, 1080, 1'b1);
		queue_random(250);
		drain_phase();

		gap_max = 20; stall_mode = 1;
		set_view_regs(2048, 65535, 1280, 1024, 1920, 1080, 1'b1);
		queue_random(250);
		drain_phase();

		gap_max = 3; stall_mode = 2;
		set_view_regs(0, 40000, 720, 576, 800, 480, 1'b0);
		queue_random(250);
		drain_phase();

		gap_max = 12; stall_mode = 1;
		set_view_regs(6000, 30000, 0, 1080, 1920, 0, 1'b1);  // zero dims
		queue_random(250);
		drain_phase();

		gap_max = 6; stall_mode = 2;
		set_view_regs(65535, 65535, 16383, 16383, 16383, 16383, 1'b1);
		queue_random(50);
		drain_phase();

		gap_max = 10; stall_mode = 1;
		set_view_regs(4096, 16384, 1080, 1920, 1920, 1080, 1'b1);
		queue_random(250);
		drain_phase();

		gap_max = 0; stall_mode = 0;
		set_view_regs(3000, 50000, 1, 1, 1, 1, 1'b0);
		queue_random(250);
		drain_phase();

		if (fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// command driver: bursts with random gaps
	always @(negedge clk) begin
		view_cmd_t item;
		if (arst_n && !(in_ch.valid && !took)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_ch.valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				item = cmd_backlog.pop_front();
				in_ch.valid      <= 1'b1;
				in_ch.cmd        <= item.cmd;
				in_ch.zoom_step  <= item.zoom_step;
				in_ch.pan_step_x <= item.pan_step_x;
				in_ch.pan_step_y <= item.pan_step_y;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left   <= $urandom_range(0, gap_max);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver stall pattern
	always @(negedge clk) begin
		if (arst_n) begin
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(3) != 0);
				default: out_ch.ready <= ((cycles % 11) < 4);
			endcase
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		view_cmd_t c;
		view_t     v;
		view_t     want;
		took = in_ch.valid && in_ch.ready;
		if (took) begin
			c.cmd        = in_ch.cmd;
			c.zoom_step  = in_ch.zoom_step;
			c.pan_step_x = in_ch.pan_step_x;
			c.pan_step_y = in_ch.pan_step_y;
			if (advance_view(c, v)) views_due.push_back(v);
		end
		if (out_ch.valid && out_ch.ready) begin
			if (views_due.size() == 0) begin
				$error("unexpected result transfer zoom_now=%0d", out_ch.zoom_now);
				fails++;
			end else begin
				want = views_due.pop_front();
				if (out_ch.zoom_now !== want.zoom_now) begin
					$error("zoom_now expected %0d actual %0d", want.zoom_now, out_ch.zoom_now);
					fails++;
				end
				if (out_ch.zoom_log2 !== want.zoom_log2) begin
					$error("zoom_log2 expected %0d actual %0d",
						want.zoom_log2, out_ch.zoom_log2);
					fails++;
				end
				if (out_ch.pan_x_now !== want.pan_x_now) begin
					$error("pan_x_now expected %0d actual %0d",
						want.pan_x_now, out_ch.pan_x_now);
					fails++;
				end
				if (out_ch.pan_y_now !== want.pan_y_now) begin
					$error("pan_y_now expected %0d actual %0d",
						want.pan_y_now, out_ch.pan_y_now);
					fails++;
				end
			end
		end
	end

	initial begin
		cycles = 0; took = 1'b0; burst_left = 0; gap_left = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
